// ===== rtl/ppp_pkg.sv =====
// Shared constants, datapath command codes and status struct of the polyline projector.
package ppp_pkg;

    localparam int MAX_POINTS   = 128;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int COORD_W      = 22;
    localparam int DIST_W       = 23;
    localparam int PROG_W       = 17;
    localparam int CNT_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 22;
    localparam int RAD_W        = 50;
    localparam int ROOT_W       = 25;
    localparam int DIV_W        = 47;
    localparam int DIV_Q_W      = 17;

    localparam logic [PROG_W-1:0] T_ONE        = 17'd65536;
    localparam logic [DIV_W-1:0]  NEAR_ZERO_SQ = 47'd6;
    localparam logic [DIST_W-1:0] DIST_MAX     = 23'd8388607;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_CAPTURE,
        CMD_SQ0,
        CMD_SQ1,
        CMD_SQRT_GO,
        CMD_DSTART,
        CMD_SEG_LD,
        CMD_DOT0,
        CMD_DOT1,
        CMD_TSEL,
        CMD_TQ,
        CMD_SCX,
        CMD_SCY,
        CMD_RES,
        CMD_DIST,
        CMD_SLEN,
        CMD_UPD,
        CMD_FIN,
        CMD_PROG,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic div_need;
        logic cnt_lt2;
        logic seg_last;
        logic trav_nz;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/ppp_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module ppp_isqrt
    import ppp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0] r_v, r_r, r_bit;
    logic             r_busy, r_done;
    logic [RAD_W-1:0] w_try;

    assign w_try = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == RAD_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_radicand;
            r_r   <= '0;
            r_bit <= RAD_W'(1) << (RAD_W - 2);
        end else if (r_busy) begin
            if (r_v >= w_try) begin
                r_v <= r_v - w_try;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

// ===== rtl/ppp_div.sv =====
// Restoring divider for a numerator no larger than the divisor; 17 quotient bits.
module ppp_div
    import ppp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_num,
    input  logic [DIV_W-1:0]   i_den,
    output logic               o_done,
    output logic [DIV_Q_W-1:0] o_quot
);

    logic [DIV_W:0]     r_rem;
    logic [DIV_W-1:0]   r_den;
    logic [DIV_Q_W-1:0] r_q;
    logic [4:0]         r_cnt;
    logic               r_busy, r_done;
    logic [DIV_W:0]     w_x;
    logic               w_ge;

    // The first step compares the numerator itself, later steps the doubled remainder.
    assign w_x  = (r_cnt == 5'd0) ? r_rem : {r_rem[DIV_W-1:0], 1'b0};
    assign w_ge = w_x >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'(DIV_Q_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_x - {1'b0, r_den}) : w_x;
            r_q   <= {r_q[DIV_Q_W-2:0], w_ge};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/ppp_dpath.sv =====
// Datapath: vertex store, configuration, shared multiplier, root and divide units, result register.
module ppp_dpath
    import ppp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [ADDR_W-1:0]            i_vertex_index,
    input  logic signed [COORD_W-1:0]    i_vertex_x,
    input  logic signed [COORD_W-1:0]    i_vertex_y,
    input  logic signed [COORD_W-1:0]    i_query_x,
    input  logic signed [COORD_W-1:0]    i_query_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [DIST_W-1:0]            o_distance_from_start,
    output logic [DIST_W-1:0]            o_distance_from_path,
    output logic [PROG_W-1:0]            o_path_progress
);

    logic [2*COORD_W-1:0] mem [MAX_POINTS];
    logic [2*COORD_W-1:0] r_rdata;

    logic [CNT_W-1:0]          r_cnt;
    logic signed [COORD_W-1:0] r_sx, r_sy, r_px, r_py, r_ax, r_ay, r_bx, r_by;
    logic [ADDR_W-1:0]         r_seg;
    logic signed [COORD_W:0]   r_abx, r_aby, r_wx, r_wy;
    logic signed [ROOT_W-1:0]  r_ex, r_ey, r_scx, r_scy;
    logic signed [RAD_W:0]     r_acc;
    logic [DIV_W-1:0]          r_lensq;
    logic [PROG_W-1:0]         r_t, r_prog;
    logic [ROOT_W-1:0]         r_dist, r_best, r_dstart, r_dpath;
    logic [ROOT_W-2:0]         r_seglen;
    logic [31:0]               r_along, r_trav;
    logic                      r_out_valid;
    logic [DIST_W-1:0]         r_o_dstart, r_o_dpath;
    logic [PROG_W-1:0]         r_o_prog;

    logic signed [COORD_W-1:0] w_vx, w_vy;
    logic signed [ROOT_W-1:0]  w_ma, w_mb;
    logic signed [RAD_W-1:0]   w_prod;
    logic [RAD_W:0]            w_rnd;
    logic [ROOT_W-1:0]         w_sc;
    logic [COORD_W:0]          w_abx_mag, w_aby_mag;
    logic [CNT_W-1:0]          w_cnt_eff;
    logic                      w_sqrt_start, w_sqrt_done, w_div_start, w_div_done, w_div_need;
    logic [RAD_W-1:0]          w_rad;
    logic [ROOT_W-1:0]         w_root;
    logic [DIV_W-1:0]          w_num, w_den;
    logic [DIV_Q_W-1:0]        w_quot;
    logic [31:0]               w_along_c;

    assign w_vx = r_rdata[2*COORD_W-1:COORD_W];
    assign w_vy = r_rdata[COORD_W-1:0];

    assign w_abx_mag = r_abx[COORD_W] ? (COORD_W+1)'(-r_abx) : r_abx;
    assign w_aby_mag = r_aby[COORD_W] ? (COORD_W+1)'(-r_aby) : r_aby;

    assign w_cnt_eff = (r_cnt > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_cnt;

    // One shared multiplier; the command picks its operands.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd)
            CMD_SQ0:  begin w_ma = r_ex; w_mb = r_ex; end
            CMD_SQ1:  begin w_ma = r_ey; w_mb = r_ey; end
            CMD_DOT0: begin w_ma = ROOT_W'(r_wx); w_mb = ROOT_W'(r_abx); end
            CMD_DOT1: begin w_ma = ROOT_W'(r_wy); w_mb = ROOT_W'(r_aby); end
            CMD_SCX:  begin w_ma = $signed({2'b00, w_abx_mag}); w_mb = $signed(ROOT_W'(r_t)); end
            CMD_SCY:  begin w_ma = $signed({2'b00, w_aby_mag}); w_mb = $signed(ROOT_W'(r_t)); end
            CMD_UPD:  begin w_ma = $signed({1'b0, r_seglen}); w_mb = $signed(ROOT_W'(r_t)); end
            default:  begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_prod    = w_ma * w_mb;
    assign w_rnd     = {1'b0, w_prod} + (RAD_W+1)'(32768);
    assign w_sc      = w_rnd[ROOT_W+15:16];
    assign w_along_c = r_trav + {6'b0, w_rnd[41:16]};

    assign w_div_need = (r_lensq > NEAR_ZERO_SQ) && (r_acc > 0)
                        && (r_acc < $signed({4'b0, r_lensq}));

    assign w_sqrt_start = (i_cmd == CMD_SQRT_GO) || (i_cmd == CMD_DIST);
    assign w_rad        = (i_cmd == CMD_DIST) ? {3'b0, r_lensq} : r_acc[RAD_W-1:0];
    assign w_div_start  = ((i_cmd == CMD_TSEL) && w_div_need)
                          || ((i_cmd == CMD_FIN) && (r_trav != '0));
    assign w_num        = (i_cmd == CMD_FIN) ? {15'b0, r_along} : r_acc[DIV_W-1:0];
    assign w_den        = (i_cmd == CMD_FIN) ? {15'b0, r_trav} : r_lensq;

    ppp_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_rad),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    ppp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_WRITE && {1'b0, i_vertex_index} < (ADDR_W+1)'(MAX_POINTS)) begin
            mem[i_vertex_index] <= {i_vertex_x, i_vertex_y};
        end
        r_rdata <= mem[r_seg];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POINT_COUNT: r_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_START_X:     r_sx  <= i_cfg_data;
                CFG_START_Y:     r_sy  <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_CAPTURE: begin
                r_px  <= i_query_x;
                r_py  <= i_query_y;
                r_ex  <= ROOT_W'(i_query_x) - ROOT_W'(r_sx);
                r_ey  <= ROOT_W'(i_query_y) - ROOT_W'(r_sy);
                r_seg <= '0;
            end
            CMD_SQ0, CMD_DOT0: begin
                r_acc <= (RAD_W+1)'(w_prod);
                if (i_cmd == CMD_DOT0) begin
                    r_lensq <= r_acc[DIV_W-1:0];
                end
            end
            CMD_SQ1, CMD_DOT1: r_acc <= r_acc + (RAD_W+1)'(w_prod);
            CMD_DSTART: begin
                r_dstart <= w_root;
                r_dpath  <= w_root;
                r_prog   <= '0;
                r_best   <= '1;
                r_along  <= '0;
                r_trav   <= '0;
                r_ax     <= w_vx;
                r_ay     <= w_vy;
                r_seg    <= ADDR_W'(1);
            end
            CMD_SEG_LD: begin
                r_bx  <= w_vx;
                r_by  <= w_vy;
                r_abx <= (COORD_W+1)'(w_vx) - (COORD_W+1)'(r_ax);
                r_aby <= (COORD_W+1)'(w_vy) - (COORD_W+1)'(r_ay);
                r_wx  <= (COORD_W+1)'(r_px) - (COORD_W+1)'(r_ax);
                r_wy  <= (COORD_W+1)'(r_py) - (COORD_W+1)'(r_ay);
                r_ex  <= ROOT_W'(w_vx) - ROOT_W'(r_ax);
                r_ey  <= ROOT_W'(w_vy) - ROOT_W'(r_ay);
            end
            CMD_TSEL: begin
                // Clamped ends; the divider fills in the interior case.
                if (r_lensq > NEAR_ZERO_SQ && r_acc > 0
                    && r_acc >= $signed({4'b0, r_lensq})) begin
                    r_t <= T_ONE;
                end else begin
                    r_t <= '0;
                end
            end
            CMD_TQ:   r_t   <= w_quot;
            CMD_SCX:  r_scx <= r_abx[COORD_W] ? -$signed(w_sc) : $signed(w_sc);
            CMD_SCY:  r_scy <= r_aby[COORD_W] ? -$signed(w_sc) : $signed(w_sc);
            CMD_RES: begin
                r_ex <= ROOT_W'(r_wx) - r_scx;
                r_ey <= ROOT_W'(r_wy) - r_scy;
            end
            CMD_DIST: r_dist   <= w_root;
            CMD_SLEN: r_seglen <= w_root[ROOT_W-2:0];
            CMD_UPD: begin
                // Strictly smaller only, so the first of equal segments wins.
                if (r_dist < r_best) begin
                    r_best  <= r_dist;
                    r_along <= w_along_c;
                end
                r_trav <= r_trav + {8'b0, r_seglen};
                r_ax   <= r_bx;
                r_ay   <= r_by;
                r_seg  <= r_seg + ADDR_W'(1);
            end
            CMD_FIN:  r_dpath <= r_best;
            CMD_PROG: r_prog  <= (w_quot > T_ONE) ? T_ONE : w_quot;
            CMD_OUT: begin
                r_o_dstart <= (r_dstart > ROOT_W'(DIST_MAX)) ? DIST_MAX : r_dstart[DIST_W-1:0];
                r_o_dpath  <= (r_dpath > ROOT_W'(DIST_MAX)) ? DIST_MAX : r_dpath[DIST_W-1:0];
                r_o_prog   <= r_prog;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.div_need  = w_div_need;
    assign o_stat.cnt_lt2   = w_cnt_eff < CNT_W'(2);
    assign o_stat.seg_last  = ({1'b0, r_seg} + CNT_W'(1)) == w_cnt_eff;
    assign o_stat.trav_nz   = r_trav != '0;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid           = r_out_valid;
    assign o_distance_from_start = r_o_dstart;
    assign o_distance_from_path  = r_o_dpath;
    assign o_path_progress       = r_o_prog;

endmodule

// ===== rtl/ppp_ctrl.sv =====
// Controller: sequences the datapath through the start distance and the segment walk.
module ppp_ctrl
    import ppp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_mode,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [24:0] {
        S_IDLE  = 25'h0000001,
        S_CSQ0  = 25'h0000002,
        S_CSQ1  = 25'h0000004,
        S_CSQRT = 25'h0000008,
        S_CWAIT = 25'h0000010,
        S_RD    = 25'h0000020,
        S_LD    = 25'h0000040,
        S_LSQ0  = 25'h0000080,
        S_LSQ1  = 25'h0000100,
        S_DOT0  = 25'h0000200,
        S_DOT1  = 25'h0000400,
        S_TSEL  = 25'h0000800,
        S_TDIV  = 25'h0001000,
        S_SCX   = 25'h0002000,
        S_SCY   = 25'h0004000,
        S_RES   = 25'h0008000,
        S_RSQ0  = 25'h0010000,
        S_RSQ1  = 25'h0020000,
        S_RSQRT = 25'h0040000,
        S_RWAIT = 25'h0080000,
        S_LWAIT = 25'h0100000,
        S_UPD   = 25'h0200000,
        S_FIN   = 25'h0400000,
        S_FWAIT = 25'h0800000,
        S_DONE  = 25'h1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode) begin
                        o_cmd   = CMD_CAPTURE;
                        n_state = S_CSQ0;
                    end else begin
                        o_cmd = CMD_WRITE;
                    end
                end
            end
            S_CSQ0:  begin o_cmd = CMD_SQ0;     n_state = S_CSQ1;  end
            S_CSQ1:  begin o_cmd = CMD_SQ1;     n_state = S_CSQRT; end
            S_CSQRT: begin o_cmd = CMD_SQRT_GO; n_state = S_CWAIT; end
            S_CWAIT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd   = CMD_DSTART;
                    n_state = i_stat.cnt_lt2 ? S_DONE : S_RD;
                end
            end
            S_RD:    n_state = S_LD;
            S_LD:    begin o_cmd = CMD_SEG_LD; n_state = S_LSQ0; end
            S_LSQ0:  begin o_cmd = CMD_SQ0;    n_state = S_LSQ1; end
            S_LSQ1:  begin o_cmd = CMD_SQ1;    n_state = S_DOT0; end
            S_DOT0:  begin o_cmd = CMD_DOT0;   n_state = S_DOT1; end
            S_DOT1:  begin o_cmd = CMD_DOT1;   n_state = S_TSEL; end
            S_TSEL: begin
                o_cmd   = CMD_TSEL;
                n_state = i_stat.div_need ? S_TDIV : S_SCX;
            end
            S_TDIV: begin
                if (i_stat.div_done) begin
                    o_cmd   = CMD_TQ;
                    n_state = S_SCX;
                end
            end
            S_SCX:   begin o_cmd = CMD_SCX;     n_state = S_SCY;   end
            S_SCY:   begin o_cmd = CMD_SCY;     n_state = S_RES;   end
            S_RES:   begin o_cmd = CMD_RES;     n_state = S_RSQ0;  end
            S_RSQ0:  begin o_cmd = CMD_SQ0;     n_state = S_RSQ1;  end
            S_RSQ1:  begin o_cmd = CMD_SQ1;     n_state = S_RSQRT; end
            S_RSQRT: begin o_cmd = CMD_SQRT_GO; n_state = S_RWAIT; end
            S_RWAIT: begin
                // Residual root done; the same unit then takes the segment length.
                if (i_stat.sqrt_done) begin
                    o_cmd   = CMD_DIST;
                    n_state = S_LWAIT;
                end
            end
            S_LWAIT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd   = CMD_SLEN;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd   = CMD_UPD;
                n_state = i_stat.seg_last ? S_FIN : S_RD;
            end
            S_FIN: begin
                o_cmd   = CMD_FIN;
                n_state = i_stat.trav_nz ? S_FWAIT : S_DONE;
            end
            S_FWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd   = CMD_PROG;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd   = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/point_to_polyline_projector.sv =====
// Top level of the point to polyline projector: controller, datapath and checks.
// A vertex write is stored on acceptance and the controller stays ready. Queries run one
// at a time: the start distance, then, with two points or more, each segment with a
// divide per interior projection, and last the progress divide for a nonzero path length.
// Synchronous active-low reset clears the controller, the result valid and the
// configuration; the vertex store is not cleared and holds undefined data until written.
module point_to_polyline_projector
    import ppp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [ADDR_W-1:0]         i_vertex_index,
    input  logic signed [COORD_W-1:0] i_vertex_x,
    input  logic signed [COORD_W-1:0] i_vertex_y,
    input  logic signed [COORD_W-1:0] i_query_x,
    input  logic signed [COORD_W-1:0] i_query_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [DIST_W-1:0]         o_distance_from_start,
    output logic [DIST_W-1:0]         o_distance_from_path,
    output logic [PROG_W-1:0]         o_path_progress
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ppp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ppp_dpath u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_vertex_index        (i_vertex_index),
        .i_vertex_x            (i_vertex_x),
        .i_vertex_y            (i_vertex_y),
        .i_query_x             (i_query_x),
        .i_query_y             (i_query_y),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_distance_from_start (o_distance_from_start),
        .o_distance_from_path  (o_distance_from_path),
        .o_path_progress       (o_path_progress)
    );

    // A query occupies the controller, so no second word is taken right after it.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode) |=> !o_in_ready)
        else $error("word accepted while a query was starting");

    // A result is only loaded when the output register is free.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == CMD_OUT) |-> w_stat.out_free)
        else $error("result loaded over a waiting result");

    // The result valid only rises after a load command.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd == CMD_OUT))
        else $error("result valid without a load");

endmodule
